FILE: design/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// types, constants and byte-level functions shared by the cipher files
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int KeyWords = 44;
    localparam int KeyAddrW = 6;

    localparam logic [1:0] RegKeyHigh = 2'd0;
    localparam logic [1:0] RegKeyLow  = 2'd1;

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StExpand = 3'd1;
    localparam logic [2:0] StPre    = 3'd2;
    localparam logic [2:0] StInit   = 3'd3;
    localparam logic [2:0] StRound  = 3'd4;

    typedef logic [127:0] block_t;
    typedef logic [31:0]  word_t;

    typedef struct packed {
        logic   start;
        logic   decrypt;
        block_t data;
        logic   first;
        logic   last;
        word_t  [3:0] rkey;
    } rnd_ctrl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a row-major state, byte 0 most significant
    function automatic logic [7:0] sbyte(input block_t s, input int i);
        return s[127-8*i -: 8];
    endfunction

endpackage

FILE: design/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// one cipher or inverse cipher round per cycle on a registered state
// ----------------------------------------------------------------------------
module aes_round (
    input  logic               clk,
    input  logic               rst_n,
    input  aes_pkg::rnd_ctrl_t ctrl,
    output aes_pkg::block_t    state
);
    import aes_pkg::*;

    block_t state_reg;
    block_t state_next;

    function automatic block_t add_rk(input block_t s, input word_t [3:0] k);
        block_t o;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                o[127-8*(r*4+c) -: 8] = sbyte(s, r*4+c) ^ k[c][31-8*r -: 8];
        return o;
    endfunction

    always_comb
    begin
        block_t t;
        block_t m;
        logic [7:0] b0, b1, b2, b3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        t = '0;
        m = '0;
        {b0, b1, b2, b3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3} = '0;
        if (ctrl.start)
        begin
            state_next = ctrl.data;
        end
        else if (ctrl.first)
        begin
            state_next = add_rk(state_reg, ctrl.rkey);
        end
        else
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    if (!ctrl.decrypt)
                        t[127-8*(r*4+c) -: 8] = sbox(sbyte(state_reg, r*4+((c+r)&3)));
                    else
                        t[127-8*(r*4+c) -: 8] = inv_sbox(sbyte(state_reg, r*4+((c+4-r)&3)));
            if (ctrl.decrypt)
                t = add_rk(t, ctrl.rkey);
            for (int c = 0; c < 4; c++)
            begin
                b0 = sbyte(t, c);
                b1 = sbyte(t, 4+c);
                b2 = sbyte(t, 8+c);
                b3 = sbyte(t, 12+c);
                x0 = xtime(b0); x1 = xtime(b1); x2 = xtime(b2); x3 = xtime(b3);
                y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
                z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
                if (!ctrl.decrypt)
                begin
                    m[127-8*c -: 8]      = x0 ^ x1 ^ b1 ^ b2 ^ b3;
                    m[127-8*(4+c) -: 8]  = b0 ^ x1 ^ x2 ^ b2 ^ b3;
                    m[127-8*(8+c) -: 8]  = b0 ^ b1 ^ x2 ^ x3 ^ b3;
                    m[127-8*(12+c) -: 8] = x0 ^ b0 ^ b1 ^ b2 ^ x3;
                end
                else
                begin
                    // 0e=z^y^x, 0b=z^x^1, 0d=z^y^1, 09=z^1
                    m[127-8*c -: 8]      = (z0^y0^x0) ^ (z1^x1^b1) ^ (z2^y2^b2) ^ (z3^b3);
                    m[127-8*(4+c) -: 8]  = (z0^b0) ^ (z1^y1^x1) ^ (z2^x2^b2) ^ (z3^y3^b3);
                    m[127-8*(8+c) -: 8]  = (z0^y0^b0) ^ (z1^b1) ^ (z2^y2^x2) ^ (z3^x3^b3);
                    m[127-8*(12+c) -: 8] = (z0^x0^b0) ^ (z1^y1^b1) ^ (z2^b2) ^ (z3^y3^x3);
                end
            end
            if (ctrl.last)
                state_next = ctrl.decrypt ? t : add_rk(t, ctrl.rkey);
            else
                state_next = ctrl.decrypt ? m : add_rk(m, ctrl.rkey);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

FILE: design/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher
// aes-128 encrypt and decrypt of one block with a stored key schedule
// ----------------------------------------------------------------------------
// the key is written through the apb port (key_high at 0x0, key_low at 0x8).
// an item is taken when start is high and busy low; mode selects encrypt (0)
// or decrypt (1). the result appears on out_high/out_low for one cycle with
// done high; the receiver cannot stall it.
// round keys sit in a 44-word memory with a registered read port, read one
// word a cycle, four words per round key.
// after a key write (and after reset) the first item expands the schedule:
// one word a cycle, feeding back through a small window of the last four
// words, before the cipher starts.
// with valid keys the block is loaded in StPre, then StRound reads the key
// words and applies each round when its fourth word arrives; busy is high after
// acceptance and drops in the done cycle, where the next item can be taken.
// reset clears control state and the key registers; no clearing pass.
// ----------------------------------------------------------------------------
module aes128_block_cipher #(
    parameter int ROUND_COUNT = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] out_high,
    output logic [63:0] out_low
);
    import aes_pkg::*;

    localparam int Words = 4 * (ROUND_COUNT + 1);
    localparam int RndW  = $clog2(ROUND_COUNT + 2);

    logic [63:0] key_high_reg, key_low_reg;
    logic        keys_valid_reg;
    logic [2:0]  st_reg, st_next;
    logic [KeyAddrW-1:0] widx_reg;
    logic [1:0]  col_reg;
    logic [RndW-1:0] rnd_reg;
    logic        dec_reg;
    logic [7:0]  rc_reg;
    word_t       win_reg [4];
    word_t       rk_reg [3];
    word_t       mem [Words];
    word_t       rdata_reg;
    logic [KeyAddrW-1:0] raddr;
    logic        done_reg;
    block_t      blk_reg;
    rnd_ctrl_t   rc;
    block_t      state;

    assign pready = 1'b1;
    logic wr_en;
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3])
            RegKeyHigh[0]: prdata = key_high_reg;
            default:       prdata = key_low_reg;
        endcase
    end

    // next expansion word
    word_t exp_w;
    always_comb
    begin
        word_t t;
        t = win_reg[3];
        if (widx_reg[1:0] == 2'd0)
        begin
            t = {t[23:0], t[31:24]};
            t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
            t = t ^ {rc_reg, 24'd0};
        end
        exp_w = win_reg[0] ^ t;
    end

    // round index to read: round keys in reverse when decrypting, 4 words each
    logic [RndW-1:0] key_rnd;
    assign key_rnd = dec_reg ? RndW'(ROUND_COUNT) - rnd_reg : rnd_reg;
    assign raddr = KeyAddrW'({key_rnd, col_reg});

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        if (st_reg == StExpand)
        begin
            if (widx_reg < KeyAddrW'(4))
                mem[widx_reg] <= win_reg[widx_reg[1:0]];
            else
                mem[widx_reg] <= exp_w;
        end
    end

    logic in_take;
    assign in_take = start && !busy;
    assign busy = (st_reg != StIdle);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            StIdle:   if (in_take) st_next = keys_valid_reg ? StPre : StExpand;
            StExpand: if (widx_reg == KeyAddrW'(Words - 1)) st_next = StPre;
            StPre:    st_next = StRound;
            StRound:  if (rnd_reg == RndW'(ROUND_COUNT + 1) && col_reg == 2'd0)
                          st_next = StIdle;
            default:  st_next = StIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= StIdle;
            key_high_reg <= '0;
            key_low_reg <= '0;
            keys_valid_reg <= 1'b0;
            done_reg <= 1'b0;
            widx_reg <= '0;
            col_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= 1'b0;
            if (wr_en)
            begin
                if (paddr[3] == RegKeyHigh[0]) key_high_reg <= pwdata;
                else key_low_reg <= pwdata;
                keys_valid_reg <= 1'b0;
            end
            case (st_reg)
                StIdle:
                begin
                    widx_reg <= '0;
                    col_reg <= '0;
                    rnd_reg <= '0;
                end
                StExpand:
                begin
                    widx_reg <= widx_reg + 1'b1;
                    if (widx_reg == KeyAddrW'(Words - 1)) keys_valid_reg <= 1'b1;
                end
                StPre:
                    col_reg <= col_reg + 1'b1;
                StRound:
                begin
                    // data for (rnd,col-1) arrives now
                    if (rnd_reg == RndW'(ROUND_COUNT + 1) && col_reg == 2'd0)
                        done_reg <= 1'b1;
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                        if (col_reg == 2'd3) rnd_reg <= rnd_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // key window, round-key gathering and block capture
    logic [1:0] got_col;
    assign got_col = col_reg - 1'b1;
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dec_reg <= mode;
            blk_reg <= {block_high, block_low};
            rc_reg <= 8'h01;
            for (int c = 0; c < 4; c++)
                win_reg[c] <= {sbyte({key_high_reg, key_low_reg}, c),
                               sbyte({key_high_reg, key_low_reg}, 4+c),
                               sbyte({key_high_reg, key_low_reg}, 8+c),
                               sbyte({key_high_reg, key_low_reg}, 12+c)};
        end
        else if (st_reg == StExpand && widx_reg >= KeyAddrW'(4))
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= win_reg[3];
            win_reg[3] <= exp_w;
            if (widx_reg[1:0] == 2'd0) rc_reg <= xtime(rc_reg);
        end
        if (st_reg == StRound && got_col != 2'd3)
            rk_reg[got_col] <= rdata_reg;
    end

    // apply a round when its fourth word arrives
    logic rnd_fire;
    logic [RndW-1:0] fire_rnd;
    assign rnd_fire = (st_reg == StRound) && (got_col == 2'd3);
    assign fire_rnd = (col_reg == 2'd0) ? rnd_reg - 1'b1 : rnd_reg;

    always_comb
    begin
        rc.start   = (st_reg == StPre);
        rc.decrypt = dec_reg;
        rc.data    = blk_reg;
        rc.first   = rnd_fire && (fire_rnd == '0);
        rc.last    = (fire_rnd == RndW'(ROUND_COUNT));
        rc.rkey    = {rdata_reg, rk_reg[2], rk_reg[1], rk_reg[0]};
    end

    // hold the state when no round fires
    rnd_ctrl_t rc_g;
    always_comb
    begin
        rc_g = rc;
        if (!rnd_fire && !rc.start)
        begin
            rc_g.start = 1'b1;
            rc_g.data  = state;
        end
    end

    aes_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rc_g),
        .state (state)
    );

    assign done = done_reg;
    assign out_high = state[127:64];
    assign out_low  = state[63:0];

endmodule

FILE: test/aes128_cipher_checker.sv
// ----------------------------------------------------------------------------
// aes128_cipher_checker
// predicts aes-128 results from accepted items and compares them with done
// ----------------------------------------------------------------------------
// watches the apb writes and the start/busy handshake, keeps its own key and
// computes the expected block; each done item is checked against the oldest
// expected block in order
// ----------------------------------------------------------------------------
module aes128_cipher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        done,
    input  logic [63:0] out_high,
    input  logic [63:0] out_low,
    output int          fail_count,
    output int          pending
);
    import aes_pkg::*;

    logic [63:0]  cur_key_high;
    logic [63:0]  cur_key_low;
    logic [127:0] cipher_q[$];

    localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    typedef logic [7:0] state_bytes_t [16];

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= x;
            x = gf_double(x);
        end
        return p;
    endfunction

    // inverse s-box built by inverting the forward table
    function automatic logic [7:0] inv_sub(input logic [7:0] a);
        for (int i = 0; i < 256; i++)
        begin
            if (FWD_BOX[i] == a)
                return 8'(i);
        end
        return 8'h00;
    endfunction

    function automatic state_bytes_t mix_cols(input logic [7:0] s [16], input logic [7:0] m [4]);
        state_bytes_t d;
        logic [7:0]   acc;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_times(m[(k + 4 - r) % 4], s[k*4+c]);
                d[r*4+c] = acc;
            end
        return d;
    endfunction

    function automatic logic [127:0] aes_transform(input logic [63:0] kh, input logic [63:0] kl,
                                                   input logic dec, input logic [127:0] blk);
        logic [31:0]  sched [44];
        logic [7:0]   kb [16];
        logic [7:0]   st [16];
        logic [7:0]   tmp [16];
        logic [7:0]   col [4];
        logic [7:0]   coef [4];
        logic [31:0]  w;
        logic [7:0]   rc;
        logic [127:0] key;
        int           rnd;
        key = {kh, kl};
        for (int i = 0; i < 16; i++)
            kb[i] = key[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            sched[c] = {kb[c], kb[4+c], kb[8+c], kb[12+c]};
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            w = sched[i-1];
            if (i % 4 == 0)
            begin
                w = {w[23:0], w[31:24]};
                w = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
                w ^= {rc, 24'h0};
                rc = gf_double(rc);
            end
            sched[i] = sched[i-4] ^ w;
        end
        for (int i = 0; i < 16; i++)
            st[i] = blk[127-8*i -: 8];
        if (dec)
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int step = 0; step <= 10; step++)
        begin
            rnd = dec ? 10 - step : step;
            if (step > 0)
            begin
                // sub and shift commute, so both directions share one order
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        tmp[r*4+c] = st[r*4 + (dec ? (c + 4 - r) % 4 : (c + r) % 4)];
                for (int i = 0; i < 16; i++)
                    st[i] = dec ? inv_sub(tmp[i]) : FWD_BOX[tmp[i]];
                if (!dec && step < 10)
                    st = mix_cols(st, coef);
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[r*4+c] ^= sched[4*rnd+c][31-8*r -: 8];
            if (dec && step > 0 && step < 10)
                st = mix_cols(st, coef);
        end
        for (int i = 0; i < 16; i++)
            aes_transform[127-8*i -: 8] = st[i];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            cur_key_high = '0;
            cur_key_low  = '0;
            fail_count   = 0;
            cipher_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 4'(RegKeyHigh * 8))
                    cur_key_high = pwdata;
                else if (paddr == 4'(RegKeyLow * 8))
                    cur_key_low = pwdata;
            end
            if (done)
            begin
                if (cipher_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h %h", out_high, out_low);
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (out_high !== want[127:64] || out_low !== want[63:0])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h %h, got %h %h",
                                     want[127:64], want[63:0], out_high, out_low);
                    end
                end
            end
            if (start && !busy)
                cipher_q = {cipher_q, aes_transform(cur_key_high, cur_key_low, mode,
                                                    {block_high, block_low})};
        end
        pending = cipher_q.size();
    end

endmodule

FILE: test/tb_aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// tb_aes128_block_cipher
// randomised regression of the aes-128 block cipher
// ----------------------------------------------------------------------------
// writes several keys over apb, including an all-one key, uses the zero reset
// key first, and sends directed and random encrypt/decrypt items with random
// gaps; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_aes128_block_cipher;
    import aes_pkg::*;

    localparam int WatchLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        mode;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        done;
    logic [63:0] out_high;
    logic [63:0] out_low;
    int          fail_count;
    int          pending;
    int          idle_cycles;

    aes128_block_cipher i_dut (.*);

    aes128_cipher_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles without an accepted item, a result or an apb access
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchLimit)
        begin
            $display("aes128_block_cipher regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic write_key(input logic [1:0] reg_index, input logic [63:0] value);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= 4'(reg_index * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // start stays high after acceptance when the next item follows at once
    task automatic send_block(input logic dec, input logic [63:0] hi, input logic [63:0] lo,
                              input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        mode       <= dec;
        block_high <= hi;
        block_low  <= lo;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
        wait_drained();
        write_key(RegKeyHigh, kh);
        write_key(RegKeyLow, kl);
    endtask

    initial
    begin
        logic [63:0] keys_high [5];
        logic [63:0] keys_low  [5];
        int gap;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        mode = 1'b0;
        block_high = '0;
        block_low = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset key of zero, with extreme blocks, before any write
        send_block(1'b0, '0, '0, 0);
        send_block(1'b1, '0, '0, 0);
        send_block(1'b0, '1, '1, 3);
        send_block(1'b1, '1, '1, 0);

        // fips-197 example key, then all ones
        set_key(64'h2b28ab097eaef7cf, 64'h15d2154f16a6883c);
        send_block(1'b0, 64'h3288313243f6a888, 64'h5a308d313198a2e0, 0);
        send_block(1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32, 1);
        send_block(1'b0, 64'h8000000000000000, 64'h0000000000000001, 0);
        send_block(1'b1, 64'h0123456789abcdef, 64'hfedcba9876543210, 0);
        set_key('1, '1);
        send_block(1'b0, '0, '1, 0);
        send_block(1'b1, '1, '0, 2);
        // key low only rewritten, so the schedule is expanded once more
        wait_drained();
        write_key(RegKeyLow, '0);
        send_block(1'b0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0);
        send_block(1'b1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0);

        keys_high = '{'0, '1, rand64(), rand64(), 64'h8000000000000001};
        keys_low  = '{'1, '0, rand64(), rand64(), 64'h0000000180000000};
        for (int phase = 0; phase < 5; phase++)
        begin
            set_key(keys_high[phase], keys_low[phase]);
            for (int n = 0; n < 110; n++)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                send_block(1'(($urandom())), rand64(), rand64(), gap);
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("aes128_block_cipher regression: pass");
        else
            $display("aes128_block_cipher regression: fail");
        $finish;
    end

endmodule

FILE: files.f
design/aes_pkg.sv
design/aes_round.sv
design/aes128_block_cipher.sv
test/aes128_cipher_checker.sv
test/tb_aes128_block_cipher.sv
